// File: rtl/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gwm_pkg;

   // Default depth of the pattern store.
   localparam int MAX_PATTERN_DEFAULT = 32;

   // Wildcard bytes.
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_ANY  = 8'h3F;

   // Command carried by each request transfer.
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   // Decoded operation strobes handed from the top level to the datapath.
   typedef struct packed {
      logic clear;
      logic append;
      logic text;
      logic finish;
   } ctl_type;

endpackage

`default_nettype wire

// File: rtl/gwm_req_if.sv
// Request channel of the glob wildcard matcher: command and byte.
// Depends on gwm_pkg for the command type.
`default_nettype none

interface gwm_req_if;
   import gwm_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   logic [7:0] ch;

   modport source (output valid, output cmd, output ch, input ready);
   modport sink   (input valid, input cmd, input ch, output ready);
endinterface

`default_nettype wire

// File: rtl/gwm_rsp_if.sv
// Response channel of the glob wildcard matcher: match flag and status.
// Depends on gwm_pkg only by convention; it carries plain bits.
`default_nettype none

interface gwm_rsp_if;
   import gwm_pkg::*;

   logic valid;
   logic ready;
   logic matched;
   logic status;

   modport source (output valid, output matched, output status, input ready);
   modport sink   (input valid, input matched, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/glob_wildcard_match.sv
// Top level of the glob wildcard matcher: input register, command decode,
// result register. Depends on gwm_pkg, gwm_req_if, gwm_rsp_if and the submodules.
//
//   Channel   Direction  Payload           Notes
//   req_port  in         cmd[1:0], ch[7:0] clear, append, text byte, end of text
//   rsp_port  out        matched, status   one transfer per end-of-text command
//
// One request is taken every cycle unless stalled; each is handled from the input register,
// where the parallel compare and star-closure prefix cover all stored positions.
// The result register is loaded as an end-of-text command is handled, so a result passes
// through the input register and the result register before it is offered.
// Synchronous active-high reset empties the pattern and both registers.
// Requests stall only while an end-of-text command waits behind an untaken result.
`default_nettype none

module glob_wildcard_match #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   gwm_req_if.sink   req_port,
   gwm_rsp_if.source rsp_port
);
   import gwm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic             in_valid_ff, in_valid_in;
   cmd_type          in_cmd_ff;
   logic [7:0]       in_ch_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_matched_ff;
   logic             out_status_ff;
   logic             out_free;
   logic             advance;
   ctl_type          ctl;
   logic [LEN_W-1:0] pat_len;
   logic             pat_ovf;
   logic [MAX_PATTERN-1:0] star_vec;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic             end_match;

   // The held command moves on unless it produces a result with no room for it.
   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && ((in_cmd_ff != CMD_END) || out_free);
   assign req_port.ready = !in_valid_ff || advance;

   // Command decode into operation strobes.
   always_comb begin
      ctl = '0;
      if (advance) begin
         unique case (in_cmd_ff)
            CMD_CLEAR:  ctl.clear  = 1'b1;
            CMD_APPEND: ctl.append = 1'b1;
            CMD_TEXT:   ctl.text   = 1'b1;
            CMD_END:    ctl.finish = 1'b1;
            default:    ctl        = '0;
         endcase
      end
   end

   // Input register.
   assign in_valid_in = req_port.ready ? req_port.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_cmd_ff <= req_port.cmd;
         in_ch_ff  <= req_port.ch;
      end
   end

   gwm_pattern_store #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .ch       (in_ch_ff),
      .len      (pat_len),
      .overflow (pat_ovf),
      .star_vec (star_vec),
      .hit_vec  (hit_vec)
   );

   gwm_positions #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_positions (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .len       (pat_len),
      .star_vec  (star_vec),
      .hit_vec   (hit_vec),
      .end_match (end_match)
   );

   // Result register: loaded on end of text, emptied by a transfer.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         out_matched_ff <= end_match && !pat_ovf;
         out_status_ff  <= pat_ovf;
      end
   end

   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.matched = out_matched_ff;
   assign rsp_port.status  = out_status_ff;

`ifndef ASSERT_OFF
   // A fresh result only follows an end-of-text command being handled.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(ctl.finish))
      else $error("result raised without end of text");

   // An overflowed pattern never reports a match.
   a_ovf_nomatch : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff) |-> !out_matched_ff)
      else $error("match reported with overflowed pattern");

   // End of text is never handled while an untaken result would be overwritten.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!out_valid_ff || rsp_port.ready))
      else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

// File: rtl/gwm_pattern_store.sv
// Pattern store, length counter and overflow flag, plus per-position
// wildcard and byte-compare vectors. Depends on gwm_pkg.
`default_nettype none

module gwm_pattern_store #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gwm_pkg::ctl_type                 ctl,
   input  logic [7:0]                       ch,
   output logic [$clog2(MAX_PATTERN+1)-1:0] len,
   output logic                             overflow,
   output logic [MAX_PATTERN-1:0]           star_vec,
   output logic [MAX_PATTERN-1:0]           hit_vec
);
   import gwm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]       store_ff [MAX_PATTERN];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             has_room;

   assign has_room = (len_ff < LEN_W'(MAX_PATTERN));

   // Length and overflow: clear empties the store, a full store drops bytes.
   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (ctl.clear) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (ctl.append) begin
         if (has_room) begin
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // Store writes need no reset; only entries below the length are used.
   always_ff @(posedge clock) begin
      if (ctl.append && has_room) begin
         store_ff[len_ff[IDX_W-1:0]] <= ch;
      end
   end

   // Every stored position is examined in parallel against the current byte.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         logic in_use;
         in_use      = (LEN_W'(i) < len_ff);
         star_vec[i] = in_use && (store_ff[i] == CHAR_STAR);
         hit_vec[i]  = in_use && (store_ff[i] != CHAR_STAR) &&
                       ((store_ff[i] == CHAR_ANY) || (store_ff[i] == ch));
      end
   end

   assign len      = len_ff;
   assign overflow = ovf_ff;

`ifndef ASSERT_OFF
   // Overflow can only be flagged once the store is completely full.
   a_ovf_full : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(MAX_PATTERN)))
      else $error("overflow flagged with store not full");
`endif

endmodule

`default_nettype wire

// File: rtl/gwm_positions.sv
// Active pattern position vector with star closure and text-byte step.
// Depends on gwm_pkg for the operation strobes.
`default_nettype none

module gwm_positions #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gwm_pkg::ctl_type                 ctl,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] len,
   input  logic [MAX_PATTERN-1:0]           star_vec,
   input  logic [MAX_PATTERN-1:0]           hit_vec,
   output logic                             end_match
);
   import gwm_pkg::*;

   localparam int POS_W  = MAX_PATTERN + 1;
   localparam int LEVELS = $clog2(MAX_PATTERN + 1);

   // The register holds positions before star closure; closure is applied on use.
   logic [POS_W-1:0] raw_ff, raw_in;
   logic [POS_W-1:0] gen_l  [LEVELS+1];
   logic [POS_W-1:0] prop_l [LEVELS+1];
   logic [POS_W-1:0] closed;
   logic [POS_W-1:0] stepped;

   // Star closure as a parallel prefix: position j is reached from an active
   // position k when every pattern byte from k up to j-1 is a star.
   always_comb begin
      gen_l[0]  = raw_ff;
      prop_l[0] = {star_vec, 1'b0};
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int j = 0; j < POS_W; j++) begin
            if (j >= (1 << lv)) begin
               gen_l[lv+1][j]  = gen_l[lv][j] | (prop_l[lv][j] & gen_l[lv][j - (1 << lv)]);
               prop_l[lv+1][j] = prop_l[lv][j] & prop_l[lv][j - (1 << lv)];
            end else begin
               gen_l[lv+1][j]  = gen_l[lv][j];
               prop_l[lv+1][j] = 1'b0;
            end
         end
      end
   end

   assign closed = gen_l[LEVELS];

   // A star keeps its position alive; a matching byte advances by one.
   assign stepped = {1'b0, closed[MAX_PATTERN-1:0] & star_vec} |
                    {closed[MAX_PATTERN-1:0] & hit_vec, 1'b0};

   always_comb begin
      raw_in = raw_ff;
      if (ctl.clear || ctl.append || ctl.finish) begin
         raw_in = POS_W'(1);
      end else if (ctl.text) begin
         raw_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= POS_W'(1);
      end else begin
         raw_ff <= raw_in;
      end
   end

   assign end_match = closed[len];

`ifndef ASSERT_OFF
   // Any restart of the text leaves only the first position pending closure.
   a_restart : assert property (@(posedge clock) disable iff (reset)
      (ctl.clear || ctl.append || ctl.finish) |=> (raw_ff == POS_W'(1)))
      else $error("text progress not restarted");
`endif

endmodule

`default_nettype wire
